[sv/rpc_pkg.sv]
`timescale 1ns / 1ps
package rpc_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int FRAC_BITS      = 16;
  localparam int GUARD          = 16;
  localparam int TABLE_LEN      = 30;

  // Datapath widths: x/y carry GUARD extra fraction bits, z is degrees with
  // 32 fraction bits.
  localparam int XY_W      = 52;
  localparam int Z_W       = 42;
  localparam int ANG_SHIFT = 32 - FRAC_BITS;

  // Angle reduction modulo a full turn, done with a reciprocal multiply.
  localparam longint FULL_TURN   = 64'sd360 << FRAC_BITS;
  localparam longint HALF_TURN   = 64'sd180 << FRAC_BITS;
  localparam int     RECIP_SHIFT = 40;
  localparam longint RECIP       = (64'sd1 << RECIP_SHIFT) / FULL_TURN;
  localparam longint OFFSET_REM  = (64'sd1 << 31) % FULL_TURN;
  localparam int     RECIP_W     = $clog2(RECIP + 1);
  localparam int     PROD_W      = 32 + RECIP_W;
  localparam int     QUO_W       = (PROD_W > RECIP_SHIFT) ? PROD_W - RECIP_SHIFT : 1;
  localparam int     FULL_W      = $clog2(FULL_TURN + 1);
  localparam int     REM_W       = FULL_W + 1;
  localparam int     QF_W        = QUO_W + FULL_W;
  localparam int     T_W         = FULL_W + 2;

  localparam logic signed [T_W-1:0] FULL_T     = T_W'(FULL_TURN);
  localparam logic signed [T_W-1:0] HALF_T     = T_W'(HALF_TURN);
  localparam logic signed [T_W-1:0] NEG_HALF_T = T_W'(-HALF_TURN);
  localparam logic signed [T_W-1:0] OFFSET_T   = T_W'(OFFSET_REM);

  localparam logic signed [Z_W-1:0] DEG90     = 42'sd386547056640;
  localparam logic signed [Z_W-1:0] NEG_DEG90 = -42'sd386547056640;
  localparam logic signed [Z_W-1:0] ROUND_Z   = Z_W'(64'sd1 << (31 - FRAC_BITS));

  // Gain multiply widths: |v| is split at bit 32 into two partial products.
  localparam int HI_W  = XY_W - 1 - 32;
  localparam int SUM_W = HI_W + 33;
  localparam int M_W   = SUM_W - GUARD;
  localparam int S_W   = M_W + 1;
  localparam logic [SUM_W-1:0] ROUND_G = SUM_W'(64'd1 << (GUARD - 1));

  // atan(2^-i) in degrees with 32 fraction bits.
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    42'sd193273528320, 42'sd114096026022, 42'sd60285206653, 42'sd30601712202,
    42'sd15360239180,  42'sd7687607525,   42'sd3844741810,  42'sd1922488225,
    42'sd961258780,    42'sd480631223,    42'sd240315841,   42'sd120157949,
    42'sd60078978,     42'sd30039489,     42'sd15019745,    42'sd7509872,
    42'sd3754936,      42'sd1877468,      42'sd938734,      42'sd469367,
    42'sd234684,       42'sd117342,       42'sd58671,       42'sd29335,
    42'sd14668,        42'sd7334,         42'sd3667,        42'sd1833,
    42'sd917,          42'sd458
  };

  typedef enum logic {
    REQ_RECT  = 1'b0,
    REQ_POLAR = 1'b1
  } req_t;

  // Fields that ride alongside the datapath from entry to output.
  typedef struct packed {
    req_t               mode;
    logic               zero;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } echo_t;

  // Square root of the CORDIC gain product, evaluated at elaboration only.
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    int          i;
    p = 64'd1 << 62;
    for (i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    v   = p;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > v) begin
      bt = bt >> 2;
    end
    while (bt != 64'd0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] hi;
    logic signed [S_W-1:0] lo;
    hi = S_W'(64'sd2147483647);
    lo = S_W'(-64'sd2147483648);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

[sv/rect_polar_converter_core.sv]
`timescale 1ns / 1ps
// Rectangular/polar vector converter, signed Q16.16 throughout.
// Input channel (in_valid / in_stall): one word per conversion. in_req_type
// selects rectangular input (x, y) or polar input (magnitude, degrees).
// Result channel (out_valid / out_stall): one word per input word, in order.
// A rectangular word returns x and y as given plus the length and atan2 in
// degrees; a polar word returns x and y plus magnitude and angle as given.
// Throughput is one word per clock while out_stall is low. The result is
// registered at the output after angle reduction (reciprocal multiply,
// remainder, fold), CORDIC setup, the CORDIC iterations, and the gain
// stages: absolute value, multiply, rounding sum and saturation.
// The receiver may hold out_stall as long as it likes: the output word stays
// put, stages behind it keep filling any empty slots, and in_stall rises only
// when every stage holds a word. Nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline; there is no other
// state, so the first word can follow in the next cycle.
module rect_polar_converter_core
  import rpc_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_first_value,
  input  logic signed [31:0] in_second_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [32:0] out_magnitude,
  output logic signed [31:0] out_angle_deg
);

  localparam int ST_MUL0  = 0;
  localparam int ST_REM   = 1;
  localparam int ST_RED   = 2;
  localparam int ST_SETUP = 3;
  localparam int ST_ABS   = ITERATIONS + 4;
  localparam int ST_GMUL  = ITERATIONS + 5;
  localparam int ST_GSUM  = ITERATIONS + 6;
  localparam int ST_OUT   = ITERATIONS + 7;
  localparam int NS       = ITERATIONS + 8;

  localparam logic [63:0] GAIN_ROOT = gain_root(ITERATIONS);
  localparam logic [31:0] GAIN      = 32'((64'd1 << 63) / GAIN_ROOT);

  // ---------------------------------------------------------------------
  // Flow control: a stage may load whenever some stage at or after it is
  // empty, or the output is being taken.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !out_stall || !(&v_r[NS-1:k]);
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  echo_t echo_nxt;
  echo_t echo_r [NS];

  always_comb begin
    echo_nxt.mode = req_t'(in_req_type);
    echo_nxt.zero = (in_first_value == 32'sd0) && (in_second_value == 32'sd0);
    echo_nxt.a    = in_first_value;
    echo_nxt.b    = in_second_value;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      echo_r[0] <= echo_nxt;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        echo_r[k] <= echo_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Angle reduction. The angle is offset by 2^31 so that it is unsigned,
  // divided by a full turn through a reciprocal multiply, and the offset's
  // own remainder is taken back out afterwards.
  logic [31:0]       u0;
  logic [PROD_W-1:0] prod0_nxt;
  logic [PROD_W-1:0] prod0_r;

  assign u0        = {~in_second_value[31], in_second_value[30:0]};
  assign prod0_nxt = PROD_W'(u0) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en[ST_MUL0]) begin
      prod0_r <= prod0_nxt;
    end
  end

  logic [31:0]      u1;
  logic [QUO_W-1:0] quo;
  logic [QF_W-1:0]  qf;
  logic [REM_W-1:0] rem_nxt;
  logic [REM_W-1:0] rem_r;

  always_comb begin
    u1      = {~echo_r[ST_MUL0].b[31], echo_r[ST_MUL0].b[30:0]};
    quo     = QUO_W'(prod0_r >> RECIP_SHIFT);
    qf      = QF_W'(quo) * QF_W'(FULL_TURN);
    // The estimate is at most one short, so this is below two full turns.
    rem_nxt = REM_W'(QF_W'(u1) - qf);
  end

  always_ff @(posedge clk) begin
    if (en[ST_REM]) begin
      rem_r <= rem_nxt;
    end
  end

  logic [REM_W-1:0]      r0;
  logic signed [T_W-1:0] t;
  logic signed [T_W-1:0] red_nxt;
  logic signed [T_W-1:0] red_r;

  always_comb begin
    r0 = (rem_r >= REM_W'(FULL_TURN)) ? rem_r - REM_W'(FULL_TURN) : rem_r;
    t  = $signed(T_W'(r0)) - OFFSET_T;
    // Fold into [-180, 180).
    if (t >= HALF_T) begin
      red_nxt = t - FULL_T;
    end else if (t < NEG_HALF_T) begin
      red_nxt = t + FULL_T;
    end else begin
      red_nxt = t;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_RED]) begin
      red_r <= red_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC setup: quadrant pre-turn so that the iterations converge.
  logic signed [XY_W-1:0] cx_r [ITERATIONS+1];
  logic signed [XY_W-1:0] cy_r [ITERATIONS+1];
  logic signed [Z_W-1:0]  cz_r [ITERATIONS+1];

  logic signed [XY_W-1:0] ax0;
  logic signed [XY_W-1:0] bx0;
  logic signed [Z_W-1:0]  zpol;
  logic signed [XY_W-1:0] x0_nxt;
  logic signed [XY_W-1:0] y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;

  always_comb begin
    ax0  = {{(XY_W-32-GUARD){echo_r[ST_RED].a[31]}}, echo_r[ST_RED].a, {GUARD{1'b0}}};
    bx0  = {{(XY_W-32-GUARD){echo_r[ST_RED].b[31]}}, echo_r[ST_RED].b, {GUARD{1'b0}}};
    zpol = {{(Z_W-T_W){red_r[T_W-1]}}, red_r} <<< ANG_SHIFT;
    if (echo_r[ST_RED].mode == REQ_RECT) begin
      x0_nxt = ax0;
      y0_nxt = bx0;
      z0_nxt = '0;
      // Left half plane: turn by a right angle toward the x axis first.
      if (echo_r[ST_RED].a[31]) begin
        if (!echo_r[ST_RED].b[31]) begin
          x0_nxt = bx0;
          y0_nxt = -ax0;
          z0_nxt = DEG90;
        end else begin
          x0_nxt = -bx0;
          y0_nxt = ax0;
          z0_nxt = NEG_DEG90;
        end
      end
    end else begin
      x0_nxt = ax0;
      y0_nxt = '0;
      z0_nxt = zpol;
      if (zpol > DEG90) begin
        x0_nxt = '0;
        y0_nxt = ax0;
        z0_nxt = zpol - DEG90;
      end else if (zpol < NEG_DEG90) begin
        x0_nxt = '0;
        y0_nxt = -ax0;
        z0_nxt = zpol + DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SETUP]) begin
      cx_r[0] <= x0_nxt;
      cy_r[0] <= y0_nxt;
      cz_r[0] <= z0_nxt;
    end
  end

  // One micro-rotation per stage. Vectoring steers on the sign of y,
  // rotation on the sign of the residual angle.
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic                   up;
    logic signed [XY_W-1:0] x_nxt;
    logic signed [XY_W-1:0] y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    always_comb begin
      if (echo_r[ST_SETUP+i].mode == REQ_RECT) begin
        up = !cy_r[i][XY_W-1];
      end else begin
        up = cz_r[i][Z_W-1];
      end
      if (up) begin
        x_nxt = cx_r[i] + (cy_r[i] >>> i);
        y_nxt = cy_r[i] - (cx_r[i] >>> i);
        z_nxt = cz_r[i] + ATAN_TAB[i];
      end else begin
        x_nxt = cx_r[i] - (cy_r[i] >>> i);
        y_nxt = cy_r[i] + (cx_r[i] >>> i);
        z_nxt = cz_r[i] - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_SETUP+1+i]) begin
        cx_r[i+1] <= x_nxt;
        cy_r[i+1] <= y_nxt;
        cz_r[i+1] <= z_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Gain correction: magnitudes times the reciprocal of the CORDIC gain, rounded half up, sign restored.
  logic                   sx_nxt;
  logic                   sy_nxt;
  logic [XY_W-2:0]        absx_nxt;
  logic [XY_W-2:0]        absy_nxt;
  logic signed [Z_W-1:0]  zr;
  logic signed [31:0]     ang_nxt;

  logic                   sx_r [ST_ABS:ST_GSUM];
  logic                   sy_r [ST_ABS:ST_GSUM];
  logic signed [31:0]     ang_r [ST_ABS:ST_GSUM];
  logic [XY_W-2:0]        absx_r;
  logic [XY_W-2:0]        absy_r;

  always_comb begin
    sx_nxt   = cx_r[ITERATIONS][XY_W-1];
    sy_nxt   = cy_r[ITERATIONS][XY_W-1];
    absx_nxt = (XY_W-1)'(sx_nxt ? -cx_r[ITERATIONS] : cx_r[ITERATIONS]);
    absy_nxt = (XY_W-1)'(sy_nxt ? -cy_r[ITERATIONS] : cy_r[ITERATIONS]);
    zr       = cz_r[ITERATIONS] + ROUND_Z;
    ang_nxt  = 32'(zr >>> ANG_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      sx_r[ST_ABS]  <= sx_nxt;
      sy_r[ST_ABS]  <= sy_nxt;
      ang_r[ST_ABS] <= ang_nxt;
      absx_r        <= absx_nxt;
      absy_r        <= absy_nxt;
    end
    for (int k = ST_GMUL; k <= ST_GSUM; k++) begin
      if (en[k]) begin
        sx_r[k]  <= sx_r[k-1];
        sy_r[k]  <= sy_r[k-1];
        ang_r[k] <= ang_r[k-1];
      end
    end
  end

  logic [63:0]        lox_nxt;
  logic [63:0]        loy_nxt;
  logic [HI_W+31:0]   hix_nxt;
  logic [HI_W+31:0]   hiy_nxt;
  logic [63:0]        lox_r;
  logic [63:0]        loy_r;
  logic [HI_W+31:0]   hix_r;
  logic [HI_W+31:0]   hiy_r;

  always_comb begin
    lox_nxt = 64'(absx_r[31:0]) * 64'(GAIN);
    loy_nxt = 64'(absy_r[31:0]) * 64'(GAIN);
    hix_nxt = (HI_W+32)'(absx_r[XY_W-2:32]) * (HI_W+32)'(GAIN);
    hiy_nxt = (HI_W+32)'(absy_r[XY_W-2:32]) * (HI_W+32)'(GAIN);
  end

  always_ff @(posedge clk) begin
    if (en[ST_GMUL]) begin
      lox_r <= lox_nxt;
      loy_r <= loy_nxt;
      hix_r <= hix_nxt;
      hiy_r <= hiy_nxt;
    end
  end

  logic [SUM_W-1:0] sumx;
  logic [SUM_W-1:0] sumy;
  logic [M_W-1:0]   mx_nxt;
  logic [M_W-1:0]   my_nxt;
  logic [M_W-1:0]   mx_r;
  logic [M_W-1:0]   my_r;

  always_comb begin
    sumx   = SUM_W'(hix_r) + SUM_W'(lox_r[63:32]) + ROUND_G;
    sumy   = SUM_W'(hiy_r) + SUM_W'(loy_r[63:32]) + ROUND_G;
    mx_nxt = M_W'(sumx >> GUARD);
    my_nxt = M_W'(sumy >> GUARD);
  end

  always_ff @(posedge clk) begin
    if (en[ST_GSUM]) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output word.
  logic signed [S_W-1:0] gx;
  logic signed [S_W-1:0] gy;
  logic signed [31:0]    x_out_nxt;
  logic signed [31:0]    y_out_nxt;
  logic signed [32:0]    mag_nxt;
  logic signed [31:0]    angle_nxt;
  logic signed [31:0]    x_out_r;
  logic signed [31:0]    y_out_r;
  logic signed [32:0]    mag_r;
  logic signed [31:0]    angle_r;

  always_comb begin
    gx = sx_r[ST_GSUM] ? -$signed({1'b0, mx_r}) : $signed({1'b0, mx_r});
    gy = sy_r[ST_GSUM] ? -$signed({1'b0, my_r}) : $signed({1'b0, my_r});
    if (echo_r[ST_GSUM].mode == REQ_RECT) begin
      x_out_nxt = echo_r[ST_GSUM].a;
      y_out_nxt = echo_r[ST_GSUM].b;
      if (echo_r[ST_GSUM].zero) begin
        mag_nxt   = '0;
        angle_nxt = '0;
      end else begin
        mag_nxt   = 33'(gx);
        angle_nxt = ang_r[ST_GSUM];
      end
    end else begin
      x_out_nxt = sat32(gx);
      y_out_nxt = sat32(gy);
      mag_nxt   = 33'(echo_r[ST_GSUM].a);
      angle_nxt = echo_r[ST_GSUM].b;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      x_out_r <= x_out_nxt;
      y_out_r <= y_out_nxt;
      mag_r   <= mag_nxt;
      angle_r <= angle_nxt;
    end
  end

  assign out_x_out     = x_out_r;
  assign out_y_out     = y_out_r;
  assign out_magnitude = mag_r;
  assign out_angle_deg = angle_r;

endmodule

[sv/rpc_checker.sv]
`timescale 1ns / 1ps
module rpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_req_type,
  input logic signed [31:0] in_first_value,
  input logic signed [31:0] in_second_value,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x_out,
  input logic signed [31:0] out_y_out,
  input logic signed [32:0] out_magnitude,
  input logic signed [31:0] out_angle_deg
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_out) && $stable(out_y_out)
      && $stable(out_magnitude) && $stable(out_angle_deg))
    else $error("stalled result word changed");

  // The input only backs up when the whole pipeline is full behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // With the receiver taking words, the input is never stalled.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the receiver is ready");

endmodule

bind rect_polar_converter_core rpc_checker u_rpc_checker (.*);
